// ===== hdl/byte_stream_hash_64_assert.svh =====
// Assertion macros for the byte stream hash block
`ifndef BYTE_STREAM_HASH_64_ASSERT_SVH
`define BYTE_STREAM_HASH_64_ASSERT_SVH
`ifndef SYNTH
`define BSH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BSH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BSH_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BSH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/bsh_pkg.sv =====
// Shared types, constants and helpers of the byte stream hash block
`default_nettype none
package bsh_pkg;

   localparam int LENGTH_BITS_DEF = 24;
   localparam int CSR_ADDR_W      = 3;

   localparam logic [63:0] SEED_K [10] = '{
      64'h6a09e667bb67ae85, 64'h3c6ef372a54ff53a, 64'h510e527f9b05688c,
      64'h1f83d9ab5be0cd19, 64'h428a2f9871374491, 64'hb5c0fbcfe9b5dba5,
      64'h3956c25b59f111f1, 64'h923f82a4ab1c5ed5, 64'hd807aa9812835b01,
      64'h243185be550c7dc3
   };

   typedef enum logic [3:0] {
      OP_NOP, OP_LATCH, OP_STORE, OP_HEAD_PRE, OP_ROUND, OP_MIX_CHAIN,
      OP_MIX_CARRY, OP_MIX_HASH, OP_CARRY_APPLY, OP_FIN_APPLY, OP_FOLD,
      OP_H_APPLY, OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      BSEL_DATA, BSEL_PAD, BSEL_HEAD0
   } bsel_type;

   typedef enum logic [1:0] {
      SH_FIRST, SH_ROUND, SH_CLOSE
   } shsel_type;

   typedef struct packed {
      op_type     op;
      bsel_type   bsel;
      shsel_type  shsel;
      logic [2:0] sel;
      logic       adv;
   } cmd_type;

   typedef struct packed {
      logic idx_lt_len;
      logic idx_lt_plen;
      logic idx_lt2;
      logic idx_eq2;
      logic mix_done;
      logic out_busy;
   } status_type;

   function automatic logic [63:0] sext8(input logic [7:0] b);
      sext8 = {{56{b[7]}}, b};
   endfunction

endpackage
`default_nettype wire

// ===== hdl/byte_stream_hash_64.sv =====
// Top level: byte stream hash, 64-bit result after the last beat
// Beats for padded bytes 0 and 1 are only stored; later ones take one 4-stage
//   compressor pass per byte, the third padded byte two passes.
// A last beat then walks the rest of the padded stream (missing bytes as zeros, then
//   up to 72 padding bytes), a closing round, 7 more passes and the output.
// Throughput is set by the single shared compressor; one beat in flight at a time.
// Synchronous active-high reset: words seeded, index and result valid cleared; length 0.
`default_nettype none
module byte_stream_hash_64
   import bsh_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input beats
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tuser,   // [0] byte_valid
   input  wire logic                  req_tlast,   // end of message
   // result beats
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [63:0]                rsp_tdata,   // [63:0] hash_value
   // register port: message_length at 0
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;

   // controller walks the padded stream and the closing steps
   bsh_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_byte_valid (req_tuser),
      .req_last       (req_tlast),
      .status         (status),
      .cmd            (cmd)
   );

   // datapath holds all words, the length register and the result beat
   bsh_dpath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_byte     (req_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );
endmodule
`default_nettype wire

// ===== hdl/bsh_mix.sv =====
// Sixteen-term compressor, four pipeline stages
`default_nettype none
`include "byte_stream_hash_64_assert.svh"
module bsh_mix
   import bsh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   input  wire logic [63:0] c,
   input  wire logic [63:0] d,
   input  wire logic [63:0] e,
   output logic             done,
   output logic [63:0]      sum
);
   logic [3:0]  vld_ff, vld_in;
   logic [63:0] s12_ff, x12_ff, n12_ff, o12_ff, s34_ff, x34_ff, e_ff;
   logic [63:0] t_ff [16];
   logic [63:0] t_in [16];
   logic [63:0] p_ff [4];
   logic [63:0] sum_ff;

   assign vld_in = {vld_ff[2:0], start};

   always_comb begin
      t_in[0]  = (s12_ff ^ x34_ff) ^ e_ff;
      t_in[1]  = (n12_ff ^ s34_ff) ^ e_ff;
      t_in[2]  = (x12_ff + s34_ff) ^ e_ff;
      t_in[3]  = (x12_ff ^ s34_ff) ^ e_ff;
      t_in[4]  = (n12_ff + s34_ff) + e_ff;
      t_in[5]  = (n12_ff + s34_ff) ^ e_ff;
      t_in[6]  = (x12_ff ^ s34_ff) ^ e_ff;
      t_in[7]  = (o12_ff ^ s34_ff) ^ e_ff;
      t_in[8]  = o12_ff | (s34_ff ^ e_ff);
      t_in[9]  = (s12_ff + s34_ff) ^ e_ff;
      t_in[10] = (s12_ff & s34_ff) ^ e_ff;
      t_in[11] = (x12_ff + x34_ff) ^ e_ff;
      t_in[12] = (o12_ff ^ x34_ff) ^ e_ff;
      t_in[13] = (s12_ff + x34_ff) ^ e_ff;
      t_in[14] = (s12_ff ^ s34_ff) ^ e_ff;
      t_in[15] = s12_ff & (s34_ff + e_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s12_ff <= a + b;
      x12_ff <= a ^ b;
      n12_ff <= a & b;
      o12_ff <= a | b;
      s34_ff <= c + d;
      x34_ff <= c ^ d;
      e_ff   <= e;
      for (int i = 0; i < 16; i++) begin
         t_ff[i] <= t_in[i];
      end
      for (int i = 0; i < 4; i++) begin
         p_ff[i] <= t_ff[4*i] + t_ff[4*i+1] + t_ff[4*i+2] + t_ff[4*i+3];
      end
      sum_ff <= p_ff[0] + p_ff[1] + p_ff[2] + p_ff[3];
   end

   assign done = vld_ff[3];
   assign sum  = sum_ff;

   `BSH_ASSERT_IMPLY(a_mix_latency, clock, reset, start, ##4 done)
endmodule
`default_nettype wire

// ===== hdl/bsh_dpath.sv =====
// Datapath: chain and carrier words, padding, fold, length register
`default_nettype none
`include "byte_stream_hash_64_assert.svh"
module bsh_dpath
   import bsh_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [63:0]                rsp_tdata
);
   localparam int IW = LENGTH_BITS + 1;

   logic [LENGTH_BITS-1:0] len_ff;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [63:0]            chain_ff [5];
   logic [63:0]            chain_in [5];
   logic [63:0]            carry_ff [5];
   logic [63:0]            carry_in [5];
   logic [7:0]             head_ff [3];
   logic [7:0]             data_ff;
   logic [63:0]            hash_ff, hash_in, out_ff, out_in;
   logic                   out_valid_ff, out_valid_in;

   logic [6:0]  gap;
   logic [7:0]  pad_add;
   logic [IW-1:0] plen;
   logic [63:0] bits64;
   logic [2:0]  bsel_j;
   logic [7:0]  pad_b, cur_b;
   logic [2:0]  r;
   logic [5:0]  s1, s2, s3, s4;
   logic [3:0]  seed_i;
   logic        mix_start, mix_done;
   logic [63:0] mix_sum, ma, mb, mc, md, me, sum3;

   // padded length and padding byte
   always_comb begin
      gap     = 7'd64 - {1'b0, len_ff[5:0]};
      pad_add = (gap >= 7'd9) ? {1'b0, gap} : ({1'b0, gap} + 8'd64);
      plen    = IW'(len_ff) + IW'(pad_add);
      bits64  = 64'(len_ff) << 3;
      bsel_j  = 3'(plen - 1'b1 - idx_ff);
      if (idx_ff == IW'(len_ff)) begin
         pad_b = 8'h80;
      end else if ((IW + 1)'(idx_ff) + (IW + 1)'(8) >= (IW + 1)'(plen)) begin
         pad_b = bits64[8*bsel_j +: 8];
      end else begin
         pad_b = 8'h00;
      end
      case (cmd.bsel)
         BSEL_DATA:  cur_b = data_ff;
         BSEL_PAD:   cur_b = (idx_ff < IW'(len_ff)) ? 8'h00 : pad_b;
         BSEL_HEAD0: cur_b = head_ff[0];
         default:    cur_b = 8'h00;
      endcase
   end

   // shift amounts of the carrier update
   always_comb begin
      r = 3'(idx_ff - 1'b1);
      case (cmd.shsel)
         SH_FIRST: begin
            s1 = 6'd2; s2 = 6'd3; s3 = 6'd4; s4 = 6'd5;
         end
         SH_CLOSE: begin
            s1 = 6'd10; s2 = 6'd19; s3 = 6'd28; s4 = 6'd37;
         end
         default: begin
            s1 = {r, 3'd2};
            s2 = {3'(r + 3'd1), 3'd3};
            s3 = {3'(r + 3'd2), 3'd4};
            s4 = {3'(r + 3'd3), 3'd5};
         end
      endcase
   end

   // compressor operand select
   always_comb begin
      mix_start = 1'b0;
      ma = chain_ff[0]; mb = chain_ff[1]; mc = chain_ff[2];
      md = chain_ff[3]; me = chain_ff[4];
      case (cmd.op)
         OP_MIX_CHAIN: mix_start = 1'b1;
         OP_MIX_CARRY: begin
            mix_start = 1'b1;
            ma = carry_ff[cmd.sel]; mb = ma; mc = ma; md = ma; me = ma;
         end
         OP_MIX_HASH: begin
            mix_start = 1'b1;
            ma = hash_ff; mb = ma; mc = ma; md = ma; me = ma;
         end
         default: mix_start = 1'b0;
      endcase
   end

   bsh_mix u_mix (
      .clock (clock),
      .reset (reset),
      .start (mix_start),
      .a     (ma),
      .b     (mb),
      .c     (mc),
      .d     (md),
      .e     (me),
      .done  (mix_done),
      .sum   (mix_sum)
   );

   always_comb begin
      seed_i = (cmd.sel == 3'd4) ? 4'd3 : {1'b0, cmd.sel};
      sum3   = mix_sum + ((cmd.op == OP_H_APPLY) ?
               ((cmd.sel == 3'd0) ? SEED_K[2] : SEED_K[7]) : SEED_K[seed_i]);
   end

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         chain_in[i] = chain_ff[i];
         carry_in[i] = carry_ff[i];
      end
      hash_in      = hash_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      idx_in       = cmd.adv ? idx_ff + 1'b1 : idx_ff;
      case (cmd.op)
         OP_HEAD_PRE: begin
            chain_in[0] = chain_ff[0] + sext8(bits64[15:8]);
            chain_in[1] = chain_ff[1] + sext8(bits64[7:0]);
            chain_in[2] = chain_ff[2] + sext8(head_ff[0]);
            chain_in[3] = chain_ff[3] + sext8(head_ff[1]);
            chain_in[4] = chain_ff[4] + sext8(cur_b);
         end
         OP_ROUND: begin
            chain_in[0] = chain_ff[0] + carry_ff[0];
            chain_in[1] = chain_ff[1] + chain_ff[2];
            chain_in[2] = chain_ff[2] + chain_ff[3];
            chain_in[3] = chain_ff[3] + sext8(cur_b);
            chain_in[4] = chain_ff[4] + carry_ff[1];
         end
         OP_CARRY_APPLY: begin
            carry_in[4] = carry_ff[4] + (carry_ff[3] >> s4);
            carry_in[3] = carry_ff[3] + (carry_ff[2] >> s3);
            carry_in[2] = carry_ff[2] + (carry_ff[1] >> s2);
            carry_in[1] = carry_ff[1] + (carry_ff[0] >> s1);
            carry_in[0] = carry_ff[0] + mix_sum;
         end
         OP_FIN_APPLY: carry_in[cmd.sel] = carry_ff[cmd.sel] + sum3;
         OP_FOLD: begin
            hash_in = (carry_ff[0] << 48) | ((carry_ff[0] + carry_ff[1]) << 32)
               | {32'd0, 32'((carry_ff[0] + carry_ff[1] + carry_ff[2]) << 16)}
               | {32'd0, 32'(carry_ff[2] + carry_ff[3] + carry_ff[4])};
         end
         OP_H_APPLY: hash_in = hash_ff + sum3;
         OP_EMIT: begin
            out_in       = hash_ff + 64'(plen) + 64'd8;
            out_valid_in = 1'b1;
            idx_in       = '0;
            for (int i = 0; i < 5; i++) begin
               chain_in[i] = SEED_K[i];
               carry_in[i] = SEED_K[i+5];
            end
         end
         default: out_in = out_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= SEED_K[i];
            carry_ff[i] <= SEED_K[i+5];
         end
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
            len_ff <= csr_pwdata[LENGTH_BITS-1:0];
         end
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= chain_in[i];
            carry_ff[i] <= carry_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      out_ff  <= out_in;
      if (cmd.op == OP_LATCH) begin
         data_ff <= in_byte;
      end
      if (cmd.op == OP_STORE) begin
         head_ff[idx_ff[1:0]] <= cur_b;
      end
      if (cmd.op == OP_HEAD_PRE) begin
         head_ff[2] <= cur_b;
      end
   end

   assign status.idx_lt_len  = idx_ff < IW'(len_ff);
   assign status.idx_lt_plen = idx_ff < plen;
   assign status.idx_lt2     = idx_ff < IW'(2);
   assign status.idx_eq2     = idx_ff == IW'(2);
   assign status.mix_done    = mix_done;
   assign status.out_busy    = out_valid_ff && !rsp_tready;

   assign csr_prdata = 32'(len_ff);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   `BSH_ASSERT_NEXT(a_emit_sets_valid, clock, reset, cmd.op == OP_EMIT, rsp_tvalid)
endmodule
`default_nettype wire

// ===== hdl/bsh_ctrl.sv =====
// Controller: sequences byte rounds, padding, finalization and output
`default_nettype none
`include "byte_stream_hash_64_assert.svh"
module bsh_ctrl
   import bsh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic       req_byte_valid,
   input  wire logic       req_last,
   input  wire status_type status,
   output cmd_type         cmd
);
   typedef enum logic [12:0] {
      S_IDLE   = 13'h0001,
      S_FEED   = 13'h0002,
      S_MIX    = 13'h0004,
      S_WAIT   = 13'h0008,
      S_ADV    = 13'h0010,
      S_CHK    = 13'h0020,
      S_CROUND = 13'h0040,
      S_FMIX   = 13'h0080,
      S_FWAIT  = 13'h0100,
      S_FOLD   = 13'h0200,
      S_HMIX   = 13'h0400,
      S_HWAIT  = 13'h0800,
      S_EMIT   = 13'h1000
   } state_type;

   state_type  state_ff, state_in;
   logic       last_ff, last_in;     // closing pending for this item
   logic       data_ff, data_in;     // current byte comes from the beat
   logic       pre_ff, pre_in;       // head pre-add done for this byte
   logic       inpre_ff, inpre_in;   // carrier update follows the pre-add
   logic       fin_ff, fin_in;       // closing round in progress
   logic [2:0] cnt_ff, cnt_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      data_in  = data_ff;
      pre_in   = pre_ff;
      inpre_in = inpre_ff;
      fin_in   = fin_ff;
      cnt_in   = cnt_ff;
      cmd      = '{op: OP_NOP, bsel: BSEL_DATA, shsel: SH_ROUND, sel: cnt_ff,
                   adv: 1'b0};
      cmd.bsel = data_ff ? BSEL_DATA : BSEL_PAD;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.op  = OP_LATCH;
               last_in = req_last;
               if (req_byte_valid && status.idx_lt_len) begin
                  data_in  = 1'b1;
                  state_in = S_FEED;
               end else if (req_last) begin
                  state_in = S_CHK;
               end
            end
         end
         S_FEED: begin
            if (status.idx_eq2 && !pre_ff) begin
               cmd.op   = OP_HEAD_PRE;
               pre_in   = 1'b1;
               inpre_in = 1'b1;
               state_in = S_MIX;
            end else if (!status.idx_lt2) begin
               cmd.op   = OP_ROUND;
               state_in = S_MIX;
            end else begin
               cmd.op   = OP_STORE;
               state_in = S_ADV;
            end
         end
         S_MIX: begin
            cmd.op   = OP_MIX_CHAIN;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            cmd.shsel = fin_ff ? SH_CLOSE : (inpre_ff ? SH_FIRST : SH_ROUND);
            if (status.mix_done) begin
               cmd.op   = OP_CARRY_APPLY;
               inpre_in = 1'b0;
               if (fin_ff) begin
                  cnt_in   = 3'd0;
                  state_in = S_FMIX;
               end else if (inpre_ff) begin
                  state_in = S_FEED;
               end else begin
                  state_in = S_ADV;
               end
            end
         end
         S_ADV: begin
            cmd.adv  = 1'b1;
            pre_in   = 1'b0;
            data_in  = 1'b0;
            state_in = last_ff ? S_CHK : S_IDLE;
         end
         S_CHK: begin
            state_in = status.idx_lt_plen ? S_FEED : S_CROUND;
         end
         S_CROUND: begin
            cmd.op   = OP_ROUND;
            cmd.bsel = BSEL_HEAD0;
            fin_in   = 1'b1;
            state_in = S_MIX;
         end
         S_FMIX: begin
            cmd.op   = OP_MIX_CARRY;
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            if (status.mix_done) begin
               cmd.op = OP_FIN_APPLY;
               if (cnt_ff == 3'd4) begin
                  cnt_in   = 3'd0;
                  state_in = S_FOLD;
               end else begin
                  cnt_in   = cnt_ff + 3'd1;
                  state_in = S_FMIX;
               end
            end
         end
         S_FOLD: begin
            cmd.op   = OP_FOLD;
            state_in = S_HMIX;
         end
         S_HMIX: begin
            cmd.op   = OP_MIX_HASH;
            state_in = S_HWAIT;
         end
         S_HWAIT: begin
            if (status.mix_done) begin
               cmd.op = OP_H_APPLY;
               if (cnt_ff == 3'd1) begin
                  state_in = S_EMIT;
               end else begin
                  cnt_in   = cnt_ff + 3'd1;
                  state_in = S_HMIX;
               end
            end
         end
         S_EMIT: begin
            if (!status.out_busy) begin
               cmd.op   = OP_EMIT;
               last_in  = 1'b0;
               fin_in   = 1'b0;
               pre_in   = 1'b0;
               cnt_in   = 3'd0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= 1'b0;
         data_ff  <= 1'b0;
         pre_ff   <= 1'b0;
         inpre_ff <= 1'b0;
         fin_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         data_ff  <= data_in;
         pre_ff   <= pre_in;
         inpre_ff <= inpre_in;
         fin_ff   <= fin_in;
         cnt_ff   <= cnt_in;
      end
   end

   `BSH_ASSERT_NEXT(a_last_blocks, clock, reset, accept && req_last, !req_tready)
endmodule
`default_nettype wire

// ===== dv/byte_stream_hash_64_tb.sv =====
// Testbench for byte_stream_hash_64: directed table plus random messages vs. a local hash model
`timescale 1ns / 1ps
`default_nettype none
module byte_stream_hash_64_tb;
   import bsh_pkg::*;

   localparam int          CYCLE_LIMIT   = 3000000;
   localparam int          ITEM_TARGET   = 850;
   localparam int          DRAIN_CYCLES  = 1000;  // wait after the queue drains
   localparam int          HOLD_CYCLES   = 3000;  // long receiver hold-off
   localparam logic [2:0]  CSR_LEN_ADDR  = 3'd0;  // message_length
   localparam logic [2:0]  CSR_SPARE_ADDR = 3'd4; // unmapped index, write ignored
   localparam logic [23:0] LEN_MAX       = 24'hFFFFFF;

   typedef enum logic {ROW_CSR, ROW_BEAT} row_kind_type;
   typedef struct {
      row_kind_type kind;
      logic [2:0]   addr;
      logic [31:0]  wdata;
      logic [7:0]   data;
      logic         valid;
      logic         last;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   byte_stream_hash_64 dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hash model state
   logic [63:0] chain_w [5];
   logic [63:0] carry_w [5];
   int unsigned pad_idx;
   logic [7:0]  head_b [3];
   logic [23:0] msg_len;          // mirror of the register

   logic [63:0] hash_q [$];       // hashes still owed by the block
   int          fail_cnt = 0;
   int          cycles = 0;
   int          beats = 0;
   int          gap_pct = 0;
   int          stall_pct = 0;
   int          hold_req = 0;     // bumped by the sender to request a hold-off
   int          hold_seen = 0;
   int          hold_left = 0;

   function automatic logic [63:0] sx8(input logic [7:0] b);
      return {{56{b[7]}}, b};
   endfunction

   function automatic logic [63:0] compress16(input logic [63:0] a, b, c, d, e);
      logic [63:0] s12, x12, n12, o12, s34, x34;
      s12 = a + b; x12 = a ^ b; n12 = a & b; o12 = a | b;
      s34 = c + d; x34 = c ^ d;
      return ((s12 ^ x34) ^ e) + ((n12 ^ s34) ^ e) + ((x12 + s34) ^ e) +
             ((x12 ^ s34) ^ e) + ((n12 + s34) + e) + ((n12 + s34) ^ e) +
             ((x12 ^ s34) ^ e) + ((o12 ^ s34) ^ e) + (o12 | (s34 ^ e)) +
             ((s12 + s34) ^ e) + ((s12 & s34) ^ e) + ((x12 + x34) ^ e) +
             ((o12 ^ x34) ^ e) + ((s12 + x34) ^ e) + ((s12 ^ s34) ^ e) +
             (s12 & (s34 + e));
   endfunction

   function automatic int unsigned padded_len(input int unsigned len);
      int unsigned tail;
      tail = len % 64;
      return len + ((64 - tail >= 9) ? (64 - tail) : (128 - tail));
   endfunction

   // padding byte at idx >= len: 0x80, zeros, then big-endian bit count
   function automatic logic [7:0] pad_at(input int unsigned len, plen, idx);
      logic [63:0] bits;
      bits = 64'(len) * 64'd8;
      if (idx == len) return 8'h80;
      if (idx + 8 >= plen) return 8'(bits >> (8 * ((plen - 1 - idx) & 7)));
      return 8'h00;
   endfunction

   task automatic hash_clear();
      for (int i = 0; i < 5; i++) begin
         chain_w[i] = SEED_K[i];
         carry_w[i] = SEED_K[i+5];
      end
      pad_idx = 0;
      head_b  = '{default: 8'h00};
   endtask

   task automatic carry_shift_mix(input int unsigned s1, s2, s3, s4);
      carry_w[4] += carry_w[3] >> (s4 & 63);
      carry_w[3] += carry_w[2] >> (s3 & 63);
      carry_w[2] += carry_w[1] >> (s2 & 63);
      carry_w[1] += carry_w[0] >> (s1 & 63);
      carry_w[0] += compress16(chain_w[0], chain_w[1], chain_w[2], chain_w[3], chain_w[4]);
   endtask

   task automatic chain_round(input int unsigned rnd, input logic [63:0] b);
      int unsigned r;
      r = rnd & 7;
      chain_w[0] += carry_w[0];
      chain_w[1] += chain_w[2];
      chain_w[2] += chain_w[3];
      chain_w[3] += b;
      chain_w[4] += carry_w[1];
      carry_shift_mix(8*r + 2, 8*((r+1) & 7) + 3, 8*((r+2) & 7) + 4, 8*((r+3) & 7) + 5);
   endtask

   task automatic absorb(input logic [7:0] b, input int unsigned len, plen);
      if (pad_idx < 3) head_b[pad_idx] = b;
      // third padded byte: fold in the tail length bytes and the head, then seed round
      if (pad_idx == 2) begin
         chain_w[0] += sx8(pad_at(len, plen, plen - 2));
         chain_w[1] += sx8(pad_at(len, plen, plen - 1));
         chain_w[2] += sx8(head_b[0]);
         chain_w[3] += sx8(head_b[1]);
         chain_w[4] += sx8(head_b[2]);
         carry_shift_mix(2, 3, 4, 5);
      end
      if (pad_idx >= 2) chain_round(pad_idx - 1, sx8(b));
      pad_idx++;
   endtask

   // advance the model by one accepted beat; queue the hash on a last beat
   task automatic hash_beat(input logic [7:0] data, input logic valid, last);
      int unsigned len, plen;
      logic [63:0] h;
      len  = msg_len;
      plen = padded_len(len);
      if (valid && pad_idx < len) absorb(data, len, plen);
      if (!last) return;
      // missing message bytes count as zeros, then the padding
      while (pad_idx < plen)
         absorb(pad_idx < len ? 8'h00 : pad_at(len, plen, pad_idx), len, plen);
      chain_w[0] += carry_w[0];
      chain_w[1] += chain_w[2];
      chain_w[2] += chain_w[3];
      chain_w[3] += sx8(head_b[0]);
      chain_w[4] += carry_w[1];
      carry_shift_mix(10, 19, 28, 37);
      for (int i = 0; i < 5; i++)
         carry_w[i] += compress16(carry_w[i], carry_w[i], carry_w[i], carry_w[i], carry_w[i])
                       + SEED_K[(i == 4) ? 3 : i];  // fifth carrier reuses the fourth seed
      h = (carry_w[0] << 48) | ((carry_w[0] + carry_w[1]) << 32) |
          (((carry_w[0] + carry_w[1] + carry_w[2]) << 16) & 64'hFFFFFFFF) |
          ((carry_w[2] + carry_w[3] + carry_w[4]) & 64'hFFFFFFFF);
      h += compress16(h, h, h, h, h) + SEED_K[2];
      h += compress16(h, h, h, h, h) + SEED_K[7];
      h += 64'(plen) + 64'd8;
      hash_q.push_back(h);
      hash_clear();
   endtask

   task automatic note_fail(input string what, input logic [63:0] exp_v, got_v);
      if (fail_cnt < 10)
         $display("MISMATCH %s: expected %h, got %h", what, exp_v, got_v);
      fail_cnt++;
   endtask

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: check each hash beat, then pick the next tready
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (hash_q.size() == 0) note_fail("unexpected hash", 64'h0, rsp_tdata);
            else begin
               logic [63:0] want;
               want = hash_q.pop_front();
               if (want !== rsp_tdata) note_fail("hash_value", want, rsp_tdata);
            end
         end
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // one input beat; valid stays up between back-to-back beats
   task automatic send_beat(input logic [7:0] data, input logic valid, last);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= valid;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hash_beat(data, valid, last);
      beats++;
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write between messages only, then read the length back
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] wdata);
      logic [31:0] rd;
      req_tvalid <= 1'b0;
      while (hash_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_access(1'b1, addr, wdata, rd);
      if (addr == CSR_LEN_ADDR) msg_len = wdata[23:0];
      @(posedge clock);
      csr_access(1'b0, CSR_LEN_ADDR, 32'h0, rd);
      if (rd !== {8'h00, msg_len}) note_fail("message_length readback", msg_len, rd);
   endtask

   stim_row_type plan [$];

   task automatic add_csr(input logic [2:0] addr, input logic [31:0] v);
      plan.push_back('{ROW_CSR, addr, v, 8'h00, 1'b0, 1'b0});
   endtask

   task automatic add_beat(input logic [7:0] d, input logic v, l);
      plan.push_back('{ROW_BEAT, CSR_LEN_ADDR, 32'h0, d, v, l});
   endtask

   // random message: mostly well formed, some noise and broken framing
   task automatic random_message();
      int unsigned len, cut;
      int          shape;
      // no register writes while a hold-off is pending, so the sender keeps pushing
      if (hold_req == hold_seen && hold_left == 0 && $urandom_range(9) < 8) begin
         case ($urandom_range(7))
            0:       len = 0;
            1:       len = $urandom_range(53, 66);   // around the 55/56 padding split
            2:       len = $urandom_range(118, 130);
            default: len = $urandom_range(1, 24);
         endcase
         csr_write(CSR_LEN_ADDR, {8'($urandom_range(255)), 24'(len)});
      end
      len   = msg_len;
      shape = $urandom_range(19);
      if (len == 0) begin
         // empty close, sometimes with an ignored byte on it
         send_beat(8'($urandom), shape < 5, 1'b1);
         return;
      end
      cut = (shape < 2) ? $urandom_range(len - 1) : len;  // early last
      for (int unsigned i = 0; i < cut; i++) begin
         if ($urandom_range(19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
         send_beat(8'($urandom), 1'b1, (i == cut - 1) && shape >= 4);
      end
      if (cut == 0 || shape < 4) begin
         // excess bytes, then a closing beat with or without a byte
         if (shape == 2 || shape == 3)
            repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 1'b1, 1'b0);
         send_beat(8'($urandom), $urandom_range(1), 1'b1);
      end
   endtask

   initial begin
      logic [31:0] rd;
      msg_len = '0;
      hash_clear();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      add_beat(8'h00, 1'b0, 1'b1);           // empty message at reset length
      add_csr(CSR_LEN_ADDR, 32'd1);
      add_beat(8'h00, 1'b1, 1'b1);
      add_beat(8'hFF, 1'b1, 1'b1);           // negative byte
      add_csr(CSR_LEN_ADDR, 32'd3);
      add_beat(8'h5A, 1'b0, 1'b0);           // beat without byte, not last
      add_beat(8'h80, 1'b1, 1'b0);
      add_beat(8'h7F, 1'b1, 1'b0);
      add_beat(8'h01, 1'b1, 1'b1);
      add_csr(CSR_LEN_ADDR, 32'd2);
      add_beat(8'hAA, 1'b1, 1'b0);
      add_beat(8'h55, 1'b1, 1'b0);
      add_beat(8'hCC, 1'b1, 1'b1);           // excess byte on the last beat
      add_csr(CSR_LEN_ADDR, 32'd55);         // padding fits in one block
      add_beat(8'h12, 1'b1, 1'b1);           // early last
      add_csr(CSR_LEN_ADDR, 32'd56);         // padding spills into a second block
      add_beat(8'h00, 1'b0, 1'b1);
      add_csr(CSR_LEN_ADDR, 32'd64);
      add_beat(8'h3C, 1'b1, 1'b1);
      add_csr(CSR_LEN_ADDR, 32'hFFFF_FFFF);  // upper bits dropped, max length
      add_csr(CSR_SPARE_ADDR, 32'd9);        // unmapped index, ignored
      add_csr(CSR_LEN_ADDR, {8'hA5, LEN_MAX ^ 24'hFFFFF8});

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) csr_write(plan[i].addr, plan[i].wdata);
         else send_beat(plan[i].data, plan[i].valid, plan[i].last);
      end

      // random messages over four idling phases
      beats = 0;
      while (beats < ITEM_TARGET) begin
         case (beats * 4 / ITEM_TARGET)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 75; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 75; end
            default: begin gap_pct = 10; stall_pct = 10; end
         endcase
         // long hold-off once, while the sender keeps pushing
         if (hold_req == 0 && beats > ITEM_TARGET / 8) hold_req = 1;
         random_message();
      end
      req_tvalid <= 1'b0;

      while (hash_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/bsh_pkg.sv
hdl/bsh_mix.sv
hdl/bsh_dpath.sv
hdl/bsh_ctrl.sv
hdl/byte_stream_hash_64.sv
dv/byte_stream_hash_64_tb.sv
